// ----- rtl/sdsi_pkg.sv -----
// Shared types, constants and the arctangent table for the stick sector indexer.
`timescale 1ns / 1ps

package sdsi_pkg;

    localparam int STICK_W   = 16;
    localparam int SEG_W     = 7;
    localparam int RAD_W     = 16;
    localparam int SECTOR_W  = 6;
    localparam int ACC_W     = 32;
    localparam int CW        = 28;
    localparam int ATAN_LEN  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_SECTORS_DEF  = 64;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [SEG_W-1:0] SEGMENT_COUNT_RST    = 7'd8;
    localparam logic [RAD_W-1:0] DEAD_ZONE_RADIUS_RST = 16'd16384;

    localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_COUNT    = 2'd0,
        CFG_DEAD_ZONE_RADIUS = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [STICK_W-1:0] stick_x;
        logic signed [STICK_W-1:0] stick_y;
    } sample_t;

    typedef struct packed {
        logic                selected;
        logic [SECTOR_W-1:0] sector;
    } result_t;

    // side flags carried alongside the angle through the pipeline
    typedef struct packed {
        logic pass;
        logic zero;
    } tag_t;

    // atan(2^-i) as a fraction of one turn, 2^32 = one turn
    function automatic logic [ACC_W-1:0] atan_turn(input int unsigned idx);
        logic [ACC_W-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/sdsi_cordic.sv -----
// Pipelined CORDIC in vectoring mode, one iteration per register stage.
`timescale 1ns / 1ps

module sdsi_cordic #(
    parameter int CORDIC_STEPS = sdsi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [sdsi_pkg::CW-1:0]     in_px,
    input  logic signed [sdsi_pkg::CW-1:0]     in_py,
    input  logic        [sdsi_pkg::ACC_W-1:0]  in_acc,
    input  sdsi_pkg::tag_t                     in_tag,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic        [sdsi_pkg::ACC_W-1:0]  out_acc,
    output sdsi_pkg::tag_t                     out_tag
);

    localparam int CW    = sdsi_pkg::CW;
    localparam int ACC_W = sdsi_pkg::ACC_W;

    logic signed [CW-1:0]    px_reg  [CORDIC_STEPS];
    logic signed [CW-1:0]    py_reg  [CORDIC_STEPS];
    logic        [ACC_W-1:0] acc_reg [CORDIC_STEPS];
    sdsi_pkg::tag_t          tag_reg [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] v_reg;

    logic signed [CW-1:0]    cur_px  [CORDIC_STEPS+1];
    logic signed [CW-1:0]    cur_py  [CORDIC_STEPS+1];
    logic        [ACC_W-1:0] cur_acc [CORDIC_STEPS+1];
    sdsi_pkg::tag_t          cur_tag [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0]   cur_v;
    logic [CORDIC_STEPS:0]   en;

    assign cur_px[0]  = in_px;
    assign cur_py[0]  = in_py;
    assign cur_acc[0] = in_acc;
    assign cur_tag[0] = in_tag;
    assign cur_v[0]   = in_valid;
    assign en[CORDIC_STEPS] = out_ready;
    assign in_ready = en[0];

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
            logic signed [CW-1:0]    dx;
            logic signed [CW-1:0]    dy;
            logic signed [CW-1:0]    px_next;
            logic signed [CW-1:0]    py_next;
            logic        [ACC_W-1:0] acc_next;

            assign cur_px[k+1]  = px_reg[k];
            assign cur_py[k+1]  = py_reg[k];
            assign cur_acc[k+1] = acc_reg[k];
            assign cur_tag[k+1] = tag_reg[k];
            assign cur_v[k+1]   = v_reg[k];
            assign en[k] = !v_reg[k] || en[k+1];

            always_comb
            begin
                dx = cur_py[k] >>> k;
                dy = cur_px[k] >>> k;
                if (!cur_py[k][CW-1])
                begin
                    px_next  = cur_px[k] + dx;
                    py_next  = cur_py[k] - dy;
                    acc_next = cur_acc[k] + sdsi_pkg::atan_turn(k);
                end
                else
                begin
                    px_next  = cur_px[k] - dx;
                    py_next  = cur_py[k] + dy;
                    acc_next = cur_acc[k] - sdsi_pkg::atan_turn(k);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    v_reg[k] <= cur_v[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    px_reg[k]  <= px_next;
                    py_reg[k]  <= py_next;
                    acc_reg[k] <= acc_next;
                    tag_reg[k] <= cur_tag[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[CORDIC_STEPS-1];
    assign out_acc   = acc_reg[CORDIC_STEPS-1];
    assign out_tag   = tag_reg[CORDIC_STEPS-1];

    // x stays non-negative after the half-turn fold; a sign flip means overflow
    a_px_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !px_reg[CORDIC_STEPS-1][CW-1])
        else $error("cordic x went negative");

endmodule

// ----- rtl/sdsi_sector.sv -----
// Angle rounding, scaling by the sector count and wrap to the sector index.
`timescale 1ns / 1ps

module sdsi_sector #(
    parameter int MAX_SECTORS = sdsi_pkg::MAX_SECTORS_DEF,
    parameter int ANGLE_BITS  = sdsi_pkg::ANGLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sdsi_pkg::SEG_W-1:0]         segment_count,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [sdsi_pkg::ACC_W-1:0]         in_acc,
    input  sdsi_pkg::tag_t                     in_tag,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sdsi_pkg::result_t                  out_result
);

    localparam int SEG_W = sdsi_pkg::SEG_W;
    localparam int ACC_W = sdsi_pkg::ACC_W;
    localparam int PW    = ANGLE_BITS + SEG_W;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (31 - ANGLE_BITS);
    localparam logic [PW-1:0]    HALF  = PW'(1) << (ANGLE_BITS - 1);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1: rounded turn fraction, clamped sector count
    logic [ACC_W-1:0]      acc_sel;
    logic [ACC_W-1:0]      turn_sum;
    logic [ANGLE_BITS-1:0] u_next;
    logic [SEG_W-1:0]      n_next;
    logic [ANGLE_BITS-1:0] u1_reg;
    logic [SEG_W-1:0]      n1_reg;
    logic                  pass1_reg;

    // stage 2: product
    logic [PW-1:0]    prod_next;
    logic [PW-1:0]    prod2_reg;
    logic [SEG_W-1:0] n2_reg;
    logic             pass2_reg;

    // stage 3: round, wrap, output word
    logic [PW-1:0]     q_sum;
    logic [SEG_W-1:0]  q;
    logic [SEG_W-1:0]  sec;
    sdsi_pkg::result_t result_next;
    sdsi_pkg::result_t result_reg;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        acc_sel  = in_tag.zero ? '0 : in_acc;
        turn_sum = acc_sel + sdsi_pkg::QUARTER_TURN + ROUND;
        u_next   = turn_sum[ACC_W-1 -: ANGLE_BITS];
        n_next   = (int'(segment_count) > MAX_SECTORS) ? SEG_W'(MAX_SECTORS) : segment_count;
    end

    assign prod_next = PW'(u1_reg) * PW'(n1_reg);

    always_comb
    begin
        q_sum = prod2_reg + HALF;
        q     = q_sum[PW-1 -: SEG_W];
        sec   = (q == n2_reg) ? '0 : q;
        result_next.selected = pass2_reg && (n2_reg != '0);
        result_next.sector   = result_next.selected ? sec[sdsi_pkg::SECTOR_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            u1_reg    <= u_next;
            n1_reg    <= n_next;
            pass1_reg <= in_tag.pass;
        end
        if (en2)
        begin
            prod2_reg <= prod_next;
            n2_reg    <= n1_reg;
            pass2_reg <= pass1_reg;
        end
        if (en3)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_result = result_reg;

    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (q <= n2_reg))
        else $error("rounded sector above sector count");

endmodule

// ----- rtl/stick_direction_sector_index.sv -----
// Top level of the stick sector indexer: config registers, magnitude test, pipeline.
`timescale 1ns / 1ps

// Maps a Q1.15 stick sample (x, y) to one of segment_count equal sectors
// centred on their nominal directions, sector 0 pointing up, or reports no
// selection in the dead zone or with zero sectors. Fully pipelined: one
// word per cycle while result_ready is high, with the CORDIC running one
// iteration per register stage. Back-pressure stalls only stages that
// hold a word; bubbles close up. Config writes are taken at once and must
// only happen while no word is in flight.

module stick_direction_sector_index #(
    parameter int MAX_SECTORS  = sdsi_pkg::MAX_SECTORS_DEF,
    parameter int ANGLE_BITS   = sdsi_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = sdsi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  sdsi_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output sdsi_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sdsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sdsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW      = sdsi_pkg::CW;
    localparam int ACC_W   = sdsi_pkg::ACC_W;
    localparam int STICK_W = sdsi_pkg::STICK_W;
    localparam int SEG_W   = sdsi_pkg::SEG_W;
    localparam int RAD_W   = sdsi_pkg::RAD_W;

    logic [SEG_W-1:0]   segment_count_reg;
    logic [RAD_W-1:0]   dead_zone_radius_reg;
    logic [2*RAD_W-1:0] rad2_reg;

    logic en_a, en_b;
    logic va_reg, vb_reg;

    // stage A: squares and half-turn fold
    logic signed [2*STICK_W-1:0] xx_next, yy_next;
    logic signed [STICK_W:0]     px17, py17;
    logic signed [CW-1:0]        px_next, py_next;
    logic [ACC_W-1:0]            acc_next;
    logic                        zero_next;
    logic signed [2*STICK_W-1:0] xx_reg, yy_reg;
    logic signed [CW-1:0]        pxa_reg, pya_reg;
    logic [ACC_W-1:0]            acca_reg;
    logic                        zeroa_reg;

    // stage B: magnitude compare
    logic [2*STICK_W-1:0]  mag2;
    sdsi_pkg::tag_t        tag_next;
    logic signed [CW-1:0]  pxb_reg, pyb_reg;
    logic [ACC_W-1:0]      accb_reg;
    sdsi_pkg::tag_t        tagb_reg;

    logic                  cordic_ready;
    logic                  cordic_valid;
    logic [ACC_W-1:0]      cordic_acc;
    sdsi_pkg::tag_t        cordic_tag;
    logic                  sector_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg    <= sdsi_pkg::SEGMENT_COUNT_RST;
            dead_zone_radius_reg <= sdsi_pkg::DEAD_ZONE_RADIUS_RST;
        end
        else if (cfg_valid)
        begin
            case (sdsi_pkg::cfg_index_t'(cfg_index))
                sdsi_pkg::CFG_SEGMENT_COUNT:    segment_count_reg    <= cfg_data[SEG_W-1:0];
                sdsi_pkg::CFG_DEAD_ZONE_RADIUS: dead_zone_radius_reg <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rad2_reg <= dead_zone_radius_reg * dead_zone_radius_reg;
    end

    assign en_b = !vb_reg || cordic_ready;
    assign en_a = !va_reg || en_b;
    assign sample_ready = en_a;

    always_comb
    begin
        xx_next   = sample.stick_x * sample.stick_x;
        yy_next   = sample.stick_y * sample.stick_y;
        zero_next = (sample.stick_x == '0) && (sample.stick_y == '0);
        if (sample.stick_x[STICK_W-1])
        begin
            px17     = -{sample.stick_x[STICK_W-1], sample.stick_x};
            py17     = {sample.stick_y[STICK_W-1], sample.stick_y};
            acc_next = sdsi_pkg::HALF_TURN;
        end
        else
        begin
            px17     = {sample.stick_x[STICK_W-1], sample.stick_x};
            py17     = -{sample.stick_y[STICK_W-1], sample.stick_y};
            acc_next = '0;
        end
        px_next = {{(CW-STICK_W-9){px17[STICK_W]}}, px17, 8'b0};
        py_next = {{(CW-STICK_W-9){py17[STICK_W]}}, py17, 8'b0};
    end

    always_comb
    begin
        mag2          = $unsigned(xx_reg) + $unsigned(yy_reg);
        tag_next.pass = (mag2 >= rad2_reg);
        tag_next.zero = zeroa_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= sample_valid;
            end
            if (en_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            xx_reg    <= xx_next;
            yy_reg    <= yy_next;
            pxa_reg   <= px_next;
            pya_reg   <= py_next;
            acca_reg  <= acc_next;
            zeroa_reg <= zero_next;
        end
        if (en_b)
        begin
            pxb_reg  <= pxa_reg;
            pyb_reg  <= pya_reg;
            accb_reg <= acca_reg;
            tagb_reg <= tag_next;
        end
    end

    sdsi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vb_reg),
        .in_ready  (cordic_ready),
        .in_px     (pxb_reg),
        .in_py     (pyb_reg),
        .in_acc    (accb_reg),
        .in_tag    (tagb_reg),
        .out_valid (cordic_valid),
        .out_ready (sector_ready),
        .out_acc   (cordic_acc),
        .out_tag   (cordic_tag)
    );

    sdsi_sector #(
        .MAX_SECTORS (MAX_SECTORS),
        .ANGLE_BITS  (ANGLE_BITS)
    ) u_sector (
        .clk           (clk),
        .rst_n         (rst_n),
        .segment_count (segment_count_reg),
        .in_valid      (cordic_valid),
        .in_ready      (sector_ready),
        .in_acc        (cordic_acc),
        .in_tag        (cordic_tag),
        .out_valid     (result_valid),
        .out_ready     (result_ready),
        .out_result    (result)
    );

    a_unsel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.selected |-> (result.sector == '0))
        else $error("sector not zero without selection");

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.selected |-> ({1'b0, result.sector} < segment_count_reg))
        else $error("sector outside sector count");

    a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
        vb_reg && tagb_reg.zero && tagb_reg.pass |-> (rad2_reg == '0))
        else $error("zero vector passed a nonzero dead zone");

endmodule
